>>> hw/rtl/sha1_pkg.sv
// Package for the SHA-1 message hasher: payload structs, front/back job
// struct and the round and initial constants. No dependencies.
package sha1_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        final_word;
  } sha1_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } sha1_out_t;

  // One job for the back end: a padded word to place in the block buffer.
  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } sha1_job_t;

  typedef enum logic [1:0] {
    BE_LOAD,
    BE_ROUND,
    BE_EMIT
  } sha1_be_state_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_ZERO,
    FE_LEN_HI,
    FE_LEN_LO
  } sha1_fe_state_t;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [159:0] H_INIT =
    {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int QDEPTH = 4;

endpackage

>>> hw/rtl/sha1_front.sv
// Front end: takes message words, tracks length and position, and expands
// the final word into padding, zero fill and length words. Uses sha1_pkg.
module sha1_front import sha1_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  sha1_in_t  in_item,
  output logic      job_valid,
  input  logic      job_ready,
  output sha1_job_t job
);

  sha1_fe_state_t state_r, state_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [2:0]  vb;
  logic [31:0] fw, mask;
  logic        two_words_r, two_words_nxt;
  logic [31:0] pend_r, pend_nxt;

  always_comb begin
    vb = (in_item.valid_bytes > 3'd4) ? 3'd4 : in_item.valid_bytes;
    case (vb)
      3'd0: mask = 32'h0;
      3'd1: mask = 32'hFF000000;
      3'd2: mask = 32'hFFFF0000;
      3'd3: mask = 32'hFFFFFF00;
      default: mask = 32'hFFFFFFFF;
    endcase
    case (vb)
      3'd0: fw = {PAD_BYTE, 24'h0};
      3'd1: fw = (in_item.data_word & mask) | {8'h0, PAD_BYTE, 16'h0};
      3'd2: fw = (in_item.data_word & mask) | {16'h0, PAD_BYTE, 8'h0};
      3'd3: fw = (in_item.data_word & mask) | {24'h0, PAD_BYTE};
      default: fw = in_item.data_word;
    endcase
  end

  assign full = (state_r != FE_IDLE) || two_words_r || !job_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    bits_nxt = bits_r;
    pos_nxt = pos_r;
    two_words_nxt = two_words_r;
    pend_nxt = pend_r;
    case (state_r)
      FE_IDLE: begin
        if (two_words_r) begin
          if (job_ready) begin
            two_words_nxt = 1'b0;
            pos_nxt = pos_r + 4'd1;
            state_nxt = FE_ZERO;
          end
        end else if (push && !full) begin
          pos_nxt = pos_r + 4'd1;
          if (!in_item.final_word) begin
            bits_nxt = bits_r + 64'd32;
          end else begin
            bits_nxt = bits_r + {58'd0, vb, 3'd0};
            if (vb == 3'd4) begin
              two_words_nxt = 1'b1;
              pend_nxt = {PAD_BYTE, 24'h0};
            end else begin
              state_nxt = FE_ZERO;
            end
          end
        end
      end
      FE_ZERO: begin
        if (pos_r == 4'd14) begin
          state_nxt = FE_LEN_HI;
        end else if (job_ready) begin
          pos_nxt = pos_r + 4'd1;
        end
      end
      FE_LEN_HI: begin
        if (job_ready) state_nxt = FE_LEN_LO;
      end
      FE_LEN_LO: begin
        if (job_ready) begin
          state_nxt = FE_IDLE;
          bits_nxt = '0;
          pos_nxt = '0;
        end
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    job_valid = 1'b0;
    job = '0;
    case (state_r)
      FE_IDLE: begin
        if (two_words_r) begin
          job_valid = job_ready;
          job.word = pend_r;
        end else if (push && !full) begin
          job_valid = 1'b1;
          job.word = in_item.final_word ? fw : in_item.data_word;
        end
      end
      FE_ZERO: begin
        job_valid = (pos_r != 4'd14) && job_ready;
      end
      FE_LEN_HI: begin
        job.word = bits_r[63:32];
        job_valid = job_ready;
      end
      FE_LEN_LO: begin
        job.word = bits_r[31:0];
        job.last = 1'b1;
        job_valid = job_ready;
      end
      default: job_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (!rst_n) begin
      state_r <= FE_IDLE;
      bits_r <= '0;
      pos_r <= '0;
      two_words_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bits_r <= bits_nxt;
      pos_r <= pos_nxt;
      two_words_r <= two_words_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst_n && job_valid) begin
      assert (job_ready) else $error("job issued while queue full");
    end
  end

  property p_len_after_zero;
    @(posedge clk) disable iff (!rst_n)
      (state_r == FE_LEN_HI) |-> (pos_r == 4'd14);
  endproperty
  a_len_after_zero: assert property (p_len_after_zero) else $error("length at wrong slot");

  property p_full_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != FE_IDLE) |-> full;
  endproperty
  a_full_busy: assert property (p_full_busy) else $error("front accepts while padding");

  property p_last_clears;
    @(posedge clk) disable iff (!rst_n)
      (job_valid && job.last) |=> (pos_r == 4'd0 && bits_r == 64'd0);
  endproperty
  a_last_clears: assert property (p_last_clears) else $error("state not cleared");

endmodule

>>> hw/rtl/sha1_queue.sv
// Short job queue between front and back end. Uses sha1_pkg.
module sha1_queue import sha1_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  sha1_job_t wr_data,
  output logic      not_full,
  output logic      not_empty,
  input  logic      rd_en,
  output sha1_job_t rd_data
);

  sha1_job_t mem_r [QDEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign not_full = cnt_r != 3'(QDEPTH);
  assign not_empty = cnt_r != 3'd0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_en} - {2'd0, rd_en};
    end
  end

endmodule

>>> hw/rtl/sha1_back.sv
// Back end: block buffer, 80-round compression at one round per cycle,
// chaining value and digest output register. Uses sha1_pkg.
module sha1_back import sha1_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  input  sha1_job_t job,
  output logic      job_take,
  output logic      empty,
  input  logic      pop,
  output sha1_out_t out_item
);

  sha1_be_state_t state_r, state_nxt;
  logic [31:0] w_r [16];
  logic [3:0]  pos_r;
  logic [6:0]  rnd_r;
  logic [159:0] h_r;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic        last_r;
  logic [2:0]  idx_r;
  logic        out_v_r;
  logic [31:0] f, k, t, wn, wi;

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = d_r ^ (b_r & (c_r ^ d_r)); k = K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = K2;
    end else begin
      f = b_r ^ c_r ^ d_r; k = K3;
    end
    wi = w_r[0];
    wn = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    wn = {wn[30:0], wn[31]};
    t = {a_r[26:0], a_r[31:27]} + f + e_r + k + wi;
  end

  assign job_take = (state_r == BE_LOAD) && job_valid;
  assign empty = !out_v_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BE_LOAD: if (job_valid && pos_r == 4'd15) state_nxt = BE_ROUND;
      BE_ROUND: if (rnd_r == 7'd79) state_nxt = BE_LOAD;
      BE_EMIT: if (pop && out_v_r && idx_r == 3'd4) state_nxt = BE_LOAD;
      default: state_nxt = BE_LOAD;
    endcase
    if (state_r == BE_ROUND && rnd_r == 7'd79 && last_r) state_nxt = BE_EMIT;
  end

  always_comb begin
    out_item.digest_word = h_r[159 - 32*idx_r -: 32];
    out_item.digest_index = idx_r;
    out_item.digest_last = idx_r == 3'd4;
  end

  always_ff @(posedge clk) begin
    if (job_take || state_r == BE_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= job_take ? job.word : wn;
    end
    if (state_r == BE_LOAD) begin
      {a_r, b_r, c_r, d_r, e_r} <= h_r;
    end else if (state_r == BE_ROUND) begin
      a_r <= t; b_r <= a_r; c_r <= {b_r[1:0], b_r[31:2]}; d_r <= c_r; e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BE_LOAD;
      pos_r <= '0;
      rnd_r <= '0;
      h_r <= H_INIT;
      last_r <= 1'b0;
      idx_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (job_take) begin
        pos_r <= pos_r + 4'd1;
        if (pos_r == 4'd15) last_r <= job.last;
      end
      if (state_r == BE_ROUND) begin
        rnd_r <= rnd_r + 7'd1;
        if (rnd_r == 7'd79) begin
          rnd_r <= '0;
          h_r <= {h_r[159:128] + t, h_r[127:96] + a_r,
                  h_r[95:64] + {b_r[1:0], b_r[31:2]}, h_r[63:32] + c_r,
                  h_r[31:0] + d_r};
          if (last_r) out_v_r <= 1'b1;
        end
      end
      if (state_r == BE_EMIT && pop && out_v_r) begin
        idx_r <= idx_r + 3'd1;
        if (idx_r == 3'd4) begin
          idx_r <= '0;
          out_v_r <= 1'b0;
          h_r <= H_INIT;
        end
      end
    end
  end

  property p_emit_valid;
    @(posedge clk) disable iff (!rst_n) out_v_r |-> (state_r == BE_EMIT);
  endproperty
  a_emit_valid: assert property (p_emit_valid) else $error("digest outside emit");

  property p_no_take_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != BE_LOAD) |-> !job_take;
  endproperty
  a_no_take_busy: assert property (p_no_take_busy) else $error("job taken while busy");

  property p_round_range;
    @(posedge clk) disable iff (!rst_n) (state_r != BE_ROUND) |-> (rnd_r == 7'd0);
  endproperty
  a_round_range: assert property (p_round_range) else $error("round counter stray");

endmodule

>>> hw/rtl/sha1_message_hasher_core.sv
// SHA-1 message hasher top level: front end, job queue, back end.
// Uses sha1_pkg, sha1_front, sha1_queue, sha1_back.
//
// Message words enter on the push/full queue side; after a final word the
// five digest words come out on the empty/pop side, index 0 first. Each
// 16-word block is loaded into the block buffer and then compressed in the
// single round unit, which takes no new words meanwhile; a final word adds
// the padding words and one or two block compressions. While a digest
// waits to be popped, words of the next message fill the four-entry job
// queue, and input then stalls until the digest has been popped.
module sha1_message_hasher_core import sha1_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  sha1_in_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output sha1_out_t out_item
);

  logic      fe_valid, q_nf, q_ne, be_take;
  sha1_job_t fe_job, q_job;

  sha1_front u_front (
    .clk, .rst_n, .push(in_push), .full(in_full), .in_item,
    .job_valid(fe_valid), .job_ready(q_nf), .job(fe_job)
  );

  sha1_queue u_queue (
    .clk, .rst_n, .wr_en(fe_valid), .wr_data(fe_job), .not_full(q_nf),
    .not_empty(q_ne), .rd_en(be_take), .rd_data(q_job)
  );

  sha1_back u_back (
    .clk, .rst_n, .job_valid(q_ne), .job(q_job), .job_take(be_take),
    .empty(out_empty), .pop(out_pop), .out_item
  );

endmodule

>>> tb/testbench.sv
// Testbench for sha1_message_hasher_core: directed and random messages, each
// digest predicted by an in-bench SHA-1 model and checked word by word.
// Depends on sha1_pkg and the hasher RTL.
`timescale 1ns / 100ps

module testbench;
  import sha1_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  sha1_in_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  sha1_out_t out_item;

  sha1_message_hasher_core DUT (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  always #5 clk = ~clk;

  logic [31:0] hash_state[5];
  logic [31:0] msg_block[16];
  int unsigned blk_pos;
  logic [63:0] msg_bits;
  sha1_out_t   digest_q[$];
  int          err_cnt = 0;
  bit          pop_en = 1'b0;

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic hash_init();
    hash_state[0] = 32'h67452301; hash_state[1] = 32'hEFCDAB89;
    hash_state[2] = 32'h98BADCFE; hash_state[3] = 32'h10325476;
    hash_state[4] = 32'hC3D2E1F0;
    blk_pos = 0;
    msg_bits = '0;
  endtask

  task automatic compress();
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
    d = hash_state[3]; e = hash_state[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = d ^ (b & (c ^ d)); k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
    hash_state[3] += d; hash_state[4] += e;
  endtask

  task automatic block_put(logic [31:0] w);
    msg_block[blk_pos] = w;
    blk_pos = (blk_pos + 1) % 16;
    if (blk_pos == 0) compress();
  endtask

  task automatic predict_digest(sha1_in_t it);
    int unsigned nb;
    int unsigned sh;
    logic [31:0] mask;
    sha1_out_t o;
    if (!it.final_word) begin
      msg_bits += 32;
      block_put(it.data_word);
      return;
    end
    nb = (it.valid_bytes > 4) ? 4 : it.valid_bytes;
    msg_bits += nb * 8;
    if (nb == 4) begin
      block_put(it.data_word);
      block_put(32'h8000_0000);
    end else begin
      sh = 8 * (4 - nb);
      mask = (sh >= 32) ? 32'h0 : (32'hFFFF_FFFF << sh);
      block_put((it.data_word & mask) | (32'(PAD_BYTE) << (sh - 8)));
    end
    if (blk_pos == 15) block_put('0);
    while (blk_pos != 14) block_put('0);
    block_put(msg_bits[63:32]);
    block_put(msg_bits[31:0]);
    for (int i = 0; i < 5; i++) begin
      o.digest_word = hash_state[i];
      o.digest_index = 3'(i);
      o.digest_last = (i == 4);
      digest_q.push_back(o);
    end
    hash_init();
  endtask

  // Send one word; returns once the transfer has happened.
  task automatic send(sha1_in_t it);
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_digest(it);
  endtask

  task automatic idle_gap(int n);
    in_push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Receiver: pop stall pattern plus checking.
  int unsigned pop_phase = 0;
  always @(posedge clk) begin
    sha1_out_t exp_o;
    if (rst_n && out_pop && !out_empty) begin
      if (digest_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("Unexpected digest word %h", out_item);
      end else begin
        exp_o = digest_q.pop_front();
        if (out_item.digest_word !== exp_o.digest_word ||
            out_item.digest_index !== exp_o.digest_index ||
            out_item.digest_last !== exp_o.digest_last) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("Digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                     exp_o.digest_word, exp_o.digest_index, exp_o.digest_last,
                     out_item.digest_word, out_item.digest_index, out_item.digest_last);
        end
      end
    end
    pop_phase <= pop_phase + 1;
    if (!pop_en) out_pop <= 1'b0;
    else if (pop_phase[9]) out_pop <= 1'b1;
    else out_pop <= (pop_phase % 7 != 3) && ($urandom_range(0, 3) != 0);
  end

  typedef struct {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        fin;
  } stim_row_t;

  stim_row_t dir_tab[9] = '{
    '{32'h0000_0000, 3'd0, 1'b1},   // empty message
    '{32'h6162_6300, 3'd3, 1'b1},   // "abc"
    '{32'hFFFF_FFFF, 3'd4, 1'b1},
    '{32'hFFFF_FFFF, 3'd1, 1'b1},
    '{32'hFFFF_FFFF, 3'd2, 1'b1},
    '{32'hA5A5_A5A5, 3'd7, 1'b1},   // byte count above 4
    '{32'h1234_5678, 3'd5, 1'b0},   // count ignored mid message
    '{32'h0000_0000, 3'd0, 1'b0},
    '{32'hDEAD_BEEF, 3'd6, 1'b1}
  };

  task automatic send_msg(int n_full, int last_bytes);
    sha1_in_t it;
    for (int i = 0; i < n_full; i++) begin
      it.data_word = $urandom;
      it.valid_bytes = 3'($urandom_range(0, 7));
      it.final_word = 1'b0;
      send(it);
      if ($urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 12));
    end
    it.data_word = $urandom;
    it.valid_bytes = 3'(last_bytes);
    it.final_word = 1'b1;
    send(it);
  endtask

  initial begin
    sha1_in_t it;
    sha1_out_t first_dig;
    int drain;
    hash_init();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    pop_en = 1'b1;

    foreach (dir_tab[i]) begin
      it.data_word = dir_tab[i].data;
      it.valid_bytes = dir_tab[i].nbytes;
      it.final_word = dir_tab[i].fin;
      send(it);
      if (i == 0) begin
        first_dig = digest_q[0];
        if (first_dig.digest_word !== 32'hDA39A3EE) begin
          err_cnt++;
          $display("Empty-message H0 predicted %h", first_dig.digest_word);
        end
      end
    end
    // 13..15 full words: padding spills into an extra block
    send_msg(13, 4);
    send_msg(14, 3);
    send_msg(15, 0);
    idle_gap(1);
    while (digest_q.size() != 0) @(posedge clk);

    for (int n = 0; n < 170; ) begin
      int len;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 17);
      send_msg(len, $urandom_range(0, 7));
      n += len + 1;
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 30));
    end
    in_push <= 1'b0;

    drain = 0;
    while (digest_q.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (200) @(posedge clk);
    if (err_cnt == 0 && digest_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_front.sv
hw/rtl/sha1_queue.sv
hw/rtl/sha1_back.sv
hw/rtl/sha1_message_hasher_core.sv
tb/testbench.sv
